// ----- src/slp_rle_pkg.sv -----
`timescale 1ns / 1ps

package slp_rle_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] CMD_ROW_START = 2'd0;
  localparam logic [1:0] CMD_STREAM    = 2'd1;
  localparam logic [1:0] CMD_PAL_WRITE = 2'd2;

  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = 8;
  localparam int RGB_W     = 24;

  // Opcodes taken from the low nibble of a command byte
  localparam logic [3:0] OP_GREATER_COPY = 4'h2;
  localparam logic [3:0] OP_GREATER_SKIP = 4'h3;
  localparam logic [3:0] OP_PLAYER_COPY  = 4'h6;
  localparam logic [3:0] OP_PAL_FILL     = 4'h7;
  localparam logic [3:0] OP_PLAYER_FILL  = 4'hA;
  localparam logic [3:0] OP_SHADOW       = 4'hB;
  localparam logic [3:0] OP_END_ROW      = 4'hF;

  // Low two opcode bits that select the lesser copy and lesser skip groups
  localparam logic [1:0] OP_GRP_COPY = 2'd0;
  localparam logic [1:0] OP_GRP_SKIP = 2'd1;

  // High nibbles of the extended command
  localparam logic [3:0] EXT_OUTLINE_A   = 4'h4;
  localparam logic [3:0] EXT_OUTLINE_B   = 4'h6;
  localparam logic [3:0] EXT_OUTLINE_A_X = 4'h5;
  localparam logic [3:0] EXT_OUTLINE_B_X = 4'h7;

  localparam logic [RGB_W-1:0] RGB_CLEAR       = 24'h000000;
  localparam logic [RGB_W-1:0] RGB_PLAYER      = 24'h0000FF;
  localparam logic [RGB_W-1:0] RGB_PLAYER_FILL = 24'h140AFF;
  localparam logic [RGB_W-1:0] RGB_OUTLINE     = 24'h00FF00;

  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
  localparam logic [7:0] ALPHA_SHADOW = 8'd100;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_COUNT   = 5'b00010,
    PH_COPY    = 5'b00100,
    PH_DISCARD = 5'b01000,
    PH_FILL    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  byte_value;
    logic [11:0] margin;
    logic [11:0] row_width;
  } item_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] run_length;
    logic        row_end;
  } run_t;

endpackage

// ----- src/slp_rle_ram.sv -----
`timescale 1ns / 1ps

module slp_rle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/slp_rle_decode.sv -----
`timescale 1ns / 1ps

module slp_rle_decode #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  slp_rle_pkg::item_t            item,
  input  logic [slp_rle_pkg::RGB_W-1:0] pal_rgb,
  output logic                          res_valid,
  output slp_rle_pkg::run_t             res
);

  localparam logic [11:0] MAX_W = 12'(MAX_WIDTH);

  slp_rle_pkg::phase_t phase, phase_next;
  logic [3:0]  pending_opcode, pending_opcode_next;
  logic [7:0]  bytes_remaining, bytes_remaining_next;
  logic [11:0] pixels_drawn, pixels_drawn_next;
  logic [11:0] width_in_use, width_in_use_next;

  logic [7:0]  b;
  logic [3:0]  op;
  logic [3:0]  hi;
  logic        start;
  logic [3:0]  start_code;
  logic [7:0]  start_n;
  logic [11:0] base;
  logic [11:0] len;
  logic        row_end;
  logic [slp_rle_pkg::RGB_W-1:0] rgb;
  logic [7:0]  alpha;
  logic [12:0] sum;
  logic [7:0]  rem_dec;

  always_comb begin
    b   = item.byte_value;
    op  = b[3:0];
    hi  = b[7:4];
    rem_dec = bytes_remaining - 8'd1;

    phase_next           = phase;
    pending_opcode_next  = pending_opcode;
    bytes_remaining_next = bytes_remaining;
    width_in_use_next    = width_in_use;
    base       = pixels_drawn;
    len        = 12'd0;
    row_end    = 1'b0;
    rgb        = slp_rle_pkg::RGB_CLEAR;
    alpha      = slp_rle_pkg::ALPHA_CLEAR;
    start      = 1'b0;
    start_code = pending_opcode;
    start_n    = 8'd0;

    case (item.cmd)
      slp_rle_pkg::CMD_ROW_START: begin
        phase_next           = slp_rle_pkg::PH_IDLE;
        pending_opcode_next  = 4'd0;
        bytes_remaining_next = 8'd0;
        width_in_use_next    = (item.row_width > MAX_W) ? MAX_W : item.row_width;
        base = 12'd0;
        len  = (item.margin > MAX_W) ? MAX_W : item.margin;
      end
      slp_rle_pkg::CMD_STREAM: begin
        case (phase)
          slp_rle_pkg::PH_COUNT: begin
            start      = 1'b1;
            start_code = pending_opcode;
            start_n    = b;
          end
          slp_rle_pkg::PH_COPY: begin
            bytes_remaining_next = rem_dec;
            if (rem_dec == 8'd0) begin
              phase_next = slp_rle_pkg::PH_IDLE;
            end
            rgb   = pal_rgb;
            alpha = slp_rle_pkg::ALPHA_OPAQUE;
            len   = 12'd1;
          end
          slp_rle_pkg::PH_DISCARD: begin
            bytes_remaining_next = rem_dec;
            if (rem_dec == 8'd0) begin
              phase_next = slp_rle_pkg::PH_IDLE;
            end
          end
          slp_rle_pkg::PH_FILL: begin
            phase_next           = slp_rle_pkg::PH_IDLE;
            bytes_remaining_next = 8'd0;
            rgb   = (pending_opcode == slp_rle_pkg::OP_PLAYER_FILL) ?
                    slp_rle_pkg::RGB_PLAYER_FILL : pal_rgb;
            alpha = slp_rle_pkg::ALPHA_OPAQUE;
            len   = {4'd0, bytes_remaining};
          end
          default: begin
            // Command byte
            phase_next          = slp_rle_pkg::PH_IDLE;
            pending_opcode_next = op;
            start_code          = op;
            if (op == slp_rle_pkg::OP_END_ROW) begin
              len     = (width_in_use > pixels_drawn) ? width_in_use - pixels_drawn : 12'd0;
              row_end = 1'b1;
            end else if (op[1:0] == slp_rle_pkg::OP_GRP_COPY) begin
              start   = 1'b1;
              start_n = {2'd0, b[7:2]};
            end else if (op[1:0] == slp_rle_pkg::OP_GRP_SKIP) begin
              if (b[7:2] == 6'd0) begin
                phase_next = slp_rle_pkg::PH_COUNT;
              end else begin
                start   = 1'b1;
                start_n = {2'd0, b[7:2]};
              end
            end else if (op == slp_rle_pkg::OP_GREATER_COPY ||
                         op == slp_rle_pkg::OP_GREATER_SKIP) begin
              phase_next = slp_rle_pkg::PH_COUNT;
            end else if (op == slp_rle_pkg::OP_PLAYER_COPY || op == slp_rle_pkg::OP_PAL_FILL ||
                         op == slp_rle_pkg::OP_PLAYER_FILL || op == slp_rle_pkg::OP_SHADOW) begin
              if (hi == 4'd0) begin
                phase_next = slp_rle_pkg::PH_COUNT;
              end else begin
                start   = 1'b1;
                start_n = {4'd0, hi};
              end
            end else begin
              // Extended: outline pixel, optionally with one ignored byte after it
              if (hi == slp_rle_pkg::EXT_OUTLINE_A || hi == slp_rle_pkg::EXT_OUTLINE_B ||
                  hi == slp_rle_pkg::EXT_OUTLINE_A_X || hi == slp_rle_pkg::EXT_OUTLINE_B_X) begin
                rgb   = slp_rle_pkg::RGB_OUTLINE;
                alpha = slp_rle_pkg::ALPHA_OPAQUE;
                len   = 12'd1;
              end
              if (hi == slp_rle_pkg::EXT_OUTLINE_A_X || hi == slp_rle_pkg::EXT_OUTLINE_B_X) begin
                phase_next           = slp_rle_pkg::PH_DISCARD;
                bytes_remaining_next = 8'd1;
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    // Opcode with its count resolved
    if (start) begin
      phase_next           = slp_rle_pkg::PH_IDLE;
      bytes_remaining_next = 8'd0;
      if (start_code[1:0] == slp_rle_pkg::OP_GRP_COPY ||
          start_code == slp_rle_pkg::OP_GREATER_COPY) begin
        if (start_n != 8'd0) begin
          phase_next           = slp_rle_pkg::PH_COPY;
          bytes_remaining_next = start_n;
        end
      end else if (start_code[1:0] == slp_rle_pkg::OP_GRP_SKIP ||
                   start_code == slp_rle_pkg::OP_GREATER_SKIP) begin
        len = {4'd0, start_n};
      end else if (start_code == slp_rle_pkg::OP_PLAYER_COPY) begin
        if (start_n != 8'd0) begin
          phase_next           = slp_rle_pkg::PH_DISCARD;
          bytes_remaining_next = start_n;
        end
        rgb   = slp_rle_pkg::RGB_PLAYER;
        alpha = slp_rle_pkg::ALPHA_OPAQUE;
        len   = {4'd0, start_n};
      end else if (start_code == slp_rle_pkg::OP_PAL_FILL ||
                   start_code == slp_rle_pkg::OP_PLAYER_FILL) begin
        phase_next           = slp_rle_pkg::PH_FILL;
        bytes_remaining_next = start_n;
      end else if (start_code == slp_rle_pkg::OP_SHADOW) begin
        alpha = slp_rle_pkg::ALPHA_SHADOW;
        len   = {4'd0, start_n};
      end
    end

    res_valid = (len != 12'd0) || row_end;
    sum = {1'b0, base} + {1'b0, len};
    pixels_drawn_next = (sum > {1'b0, MAX_W}) ? MAX_W : sum[11:0];

    res.red        = rgb[23:16];
    res.green      = rgb[15:8];
    res.blue       = rgb[7:0];
    res.alpha      = alpha;
    res.run_length = len;
    res.row_end    = row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= slp_rle_pkg::PH_IDLE;
      pending_opcode  <= 4'd0;
      bytes_remaining <= 8'd0;
      pixels_drawn    <= 12'd0;
      width_in_use    <= 12'd0;
    end else if (step) begin
      phase           <= phase_next;
      pending_opcode  <= pending_opcode_next;
      bytes_remaining <= bytes_remaining_next;
      pixels_drawn    <= pixels_drawn_next;
      width_in_use    <= width_in_use_next;
    end
  end

endmodule

// ----- src/slp_sprite_row_rle_decoder_unit.sv -----
`timescale 1ns / 1ps
// Path: an accepted input item is held in the input register, and its result item
// is loaded into the output register when that register is free or draining.
// Throughput: one item per cycle without output back-pressure; the input register
// and the palette read register feed the decoder; the output register holds the result.
// Reset (rst, synchronous, active high) clears the decoder state and the valid
// flags; palette contents are undefined until written.

module slp_sprite_row_rle_decoder_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte_value [7:0], margin [19:8], row_width [31:20], palette_color [55:32]
  input  logic [55:0] s_axis_tdata,
  // command [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24], run_length [43:32], zero [47:44]
  output logic [47:0] m_axis_tdata,
  // row_end
  output logic        m_axis_tlast
);

  logic                          accept;
  logic                          advance;
  logic                          s1_valid;
  slp_rle_pkg::item_t            s1_item;
  logic [slp_rle_pkg::RGB_W-1:0] pal_rgb;
  logic                          res_valid;
  slp_rle_pkg::run_t             res;
  logic                          out_valid;
  slp_rle_pkg::run_t             out_run;

  // Advance the input register whenever the output register is free or draining.
  assign advance       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Palette: write on a palette write item, read on every accepted item so the
  // entry lines up with the item in the input register.
  slp_rle_ram #(
    .WIDTH(slp_rle_pkg::RGB_W),
    .DEPTH(slp_rle_pkg::PAL_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (accept && (s_axis_tuser == slp_rle_pkg::CMD_PAL_WRITE)),
    .wr_addr(s_axis_tdata[slp_rle_pkg::PAL_AW-1:0]),
    .wr_data(s_axis_tdata[55:32]),
    .rd_en  (accept),
    .rd_addr(s_axis_tdata[slp_rle_pkg::PAL_AW-1:0]),
    .rd_data(pal_rgb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Hold the item while it waits.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.cmd        <= s_axis_tuser;
      s1_item.byte_value <= s_axis_tdata[7:0];
      s1_item.margin     <= s_axis_tdata[19:8];
      s1_item.row_width  <= s_axis_tdata[31:20];
    end
  end

  slp_rle_decode #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (s1_item),
    .pal_rgb  (pal_rgb),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_run <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_run.run_length, out_run.alpha,
                          out_run.blue, out_run.green, out_run.red};
  assign m_axis_tlast  = out_run.row_end;

  a_pad_transparent: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[31:24] == slp_rle_pkg::ALPHA_CLEAR))
    else $error("row end run is not transparent");

  a_pal_write_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_item.cmd == slp_rle_pkg::CMD_PAL_WRITE)) |=> !m_axis_tvalid)
    else $error("palette write produced a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

endmodule

// ----- tb/tb_slp_sprite_row_rle_decoder_unit.sv -----
`timescale 1ns / 1ps

module tb_slp_sprite_row_rle_decoder_unit;

  localparam int MAX_W = 2048;
  localparam int RAND_ITEMS = 700;
  localparam int CYCLE_LIMIT = 200000;
  // Input kind with no meaning to the block; it must be dropped silently
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Extended command opcode (low nibble)
  localparam logic [3:0] OP_EXTENDED = 4'hE;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // byte_value [7:0], margin [19:8], row_width [31:20], palette_color [55:32]
  logic [55:0] s_axis_tdata = '0;
  // command [1:0]
  logic [1:0]  s_axis_tuser = slp_rle_pkg::CMD_ROW_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // red [7:0], green [15:8], blue [23:16], alpha [31:24], run_length [43:32], zero [47:44]
  logic [47:0] m_axis_tdata;
  // row_end
  logic        m_axis_tlast;

  // Predicts the pixel runs of the decoder from the accepted input items and
  // holds them until the block delivers them.
  class run_tracker;
    slp_rle_pkg::phase_t phase;
    logic [3:0]  pend_op;
    logic [7:0]  bytes_left;
    int          drawn_px;
    int          row_limit;
    logic [23:0] pal [slp_rle_pkg::PAL_DEPTH];
    bit          written [slp_rle_pkg::PAL_DEPTH];
    slp_rle_pkg::run_t runs_due [$];
    int          fails;

    function new();
      phase = slp_rle_pkg::PH_IDLE;
      pend_op = 4'h0;
      bytes_left = 8'd0;
      drawn_px = 0;
      row_limit = 0;
      fails = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int clamp_w(int v);
      return v > MAX_W ? MAX_W : v;
    endfunction

    // Queue one run; zero-length runs vanish unless they close the row.
    function void emit(logic [23:0] rgb, logic [7:0] a, int len, bit last);
      slp_rle_pkg::run_t r;
      if (len == 0 && !last) return;
      r.red = rgb[23:16];
      r.green = rgb[15:8];
      r.blue = rgb[7:0];
      r.alpha = a;
      r.run_length = len[11:0];
      r.row_end = last;
      runs_due = {runs_due, r};
      drawn_px = clamp_w(drawn_px + len);
    endfunction

    // Act on an opcode once its count is known.
    function void start_op(logic [3:0] op, int n);
      phase = slp_rle_pkg::PH_IDLE;
      bytes_left = 8'd0;
      if (op[1:0] == slp_rle_pkg::OP_GRP_COPY || op == slp_rle_pkg::OP_GREATER_COPY) begin
        if (n != 0) begin
          phase = slp_rle_pkg::PH_COPY;
          bytes_left = n[7:0];
        end
      end else if (op[1:0] == slp_rle_pkg::OP_GRP_SKIP ||
                   op == slp_rle_pkg::OP_GREATER_SKIP) begin
        emit(slp_rle_pkg::RGB_CLEAR, slp_rle_pkg::ALPHA_CLEAR, n, 1'b0);
      end else if (op == slp_rle_pkg::OP_PLAYER_COPY) begin
        if (n != 0) begin
          phase = slp_rle_pkg::PH_DISCARD;
          bytes_left = n[7:0];
        end
        emit(slp_rle_pkg::RGB_PLAYER, slp_rle_pkg::ALPHA_OPAQUE, n, 1'b0);
      end else if (op == slp_rle_pkg::OP_PAL_FILL || op == slp_rle_pkg::OP_PLAYER_FILL) begin
        phase = slp_rle_pkg::PH_FILL;
        bytes_left = n[7:0];
      end else if (op == slp_rle_pkg::OP_SHADOW) begin
        emit(slp_rle_pkg::RGB_CLEAR, slp_rle_pkg::ALPHA_SHADOW, n, 1'b0);
      end
    endfunction

    function void command_byte(logic [7:0] b);
      logic [3:0] op;
      logic [3:0] hi;
      int pad;
      op = b[3:0];
      hi = b[7:4];
      pend_op = op;
      if (op == slp_rle_pkg::OP_END_ROW) begin
        pad = row_limit > drawn_px ? row_limit - drawn_px : 0;
        emit(slp_rle_pkg::RGB_CLEAR, slp_rle_pkg::ALPHA_CLEAR, pad, 1'b1);
      end else if (op[1:0] == slp_rle_pkg::OP_GRP_COPY) begin
        start_op(op, int'(b[7:2]));
      end else if (op[1:0] == slp_rle_pkg::OP_GRP_SKIP) begin
        if (b[7:2] == 6'd0) phase = slp_rle_pkg::PH_COUNT;
        else start_op(op, int'(b[7:2]));
      end else if (op == slp_rle_pkg::OP_GREATER_COPY || op == slp_rle_pkg::OP_GREATER_SKIP) begin
        phase = slp_rle_pkg::PH_COUNT;
      end else if (op == slp_rle_pkg::OP_PLAYER_COPY || op == slp_rle_pkg::OP_PAL_FILL ||
                   op == slp_rle_pkg::OP_PLAYER_FILL || op == slp_rle_pkg::OP_SHADOW) begin
        if (hi == 4'h0) phase = slp_rle_pkg::PH_COUNT;
        else start_op(op, int'(hi));
      end else if (op == OP_EXTENDED) begin
        if (hi == slp_rle_pkg::EXT_OUTLINE_A || hi == slp_rle_pkg::EXT_OUTLINE_B) begin
          emit(slp_rle_pkg::RGB_OUTLINE, slp_rle_pkg::ALPHA_OPAQUE, 1, 1'b0);
        end else if (hi == slp_rle_pkg::EXT_OUTLINE_A_X ||
                     hi == slp_rle_pkg::EXT_OUTLINE_B_X) begin
          phase = slp_rle_pkg::PH_DISCARD;
          bytes_left = 8'd1;
          emit(slp_rle_pkg::RGB_OUTLINE, slp_rle_pkg::ALPHA_OPAQUE, 1, 1'b0);
        end
      end
    endfunction

    function void stream_byte(logic [7:0] b);
      int n;
      logic [23:0] rgb;
      case (phase)
        slp_rle_pkg::PH_COUNT: start_op(pend_op, int'(b));
        slp_rle_pkg::PH_COPY: begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) phase = slp_rle_pkg::PH_IDLE;
          emit(pal[b], slp_rle_pkg::ALPHA_OPAQUE, 1, 1'b0);
        end
        slp_rle_pkg::PH_DISCARD: begin
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'd0) phase = slp_rle_pkg::PH_IDLE;
        end
        slp_rle_pkg::PH_FILL: begin
          n = int'(bytes_left);
          rgb = (pend_op == slp_rle_pkg::OP_PLAYER_FILL) ? slp_rle_pkg::RGB_PLAYER_FILL : pal[b];
          phase = slp_rle_pkg::PH_IDLE;
          bytes_left = 8'd0;
          emit(rgb, slp_rle_pkg::ALPHA_OPAQUE, n, 1'b0);
        end
        default: begin
          phase = slp_rle_pkg::PH_IDLE;
          command_byte(b);
        end
      endcase
    endfunction

    // Note one accepted input item.
    function void take_item(logic [1:0] cmd, logic [55:0] data);
      case (cmd)
        slp_rle_pkg::CMD_ROW_START: begin
          phase = slp_rle_pkg::PH_IDLE;
          pend_op = 4'h0;
          bytes_left = 8'd0;
          row_limit = clamp_w(int'(data[31:20]));
          drawn_px = 0;
          emit(slp_rle_pkg::RGB_CLEAR, slp_rle_pkg::ALPHA_CLEAR,
               clamp_w(int'(data[19:8])), 1'b0);
        end
        slp_rle_pkg::CMD_STREAM: stream_byte(data[7:0]);
        slp_rle_pkg::CMD_PAL_WRITE: begin
          pal[data[7:0]] = data[55:32];
          written[data[7:0]] = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // True when the next stream byte is taken as a palette index.
    function bit reads_palette();
      return phase == slp_rle_pkg::PH_COPY ||
             (phase == slp_rle_pkg::PH_FILL && pend_op == slp_rle_pkg::OP_PAL_FILL);
    endfunction

    function void cmp(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    // Compare one delivered run with the oldest prediction.
    function void check_run(logic [47:0] data, logic last);
      slp_rle_pkg::run_t want;
      if (runs_due.size() == 0) begin
        $error("run item with nothing expected: tdata %h tlast %b", data, last);
        fails++;
        return;
      end
      want = runs_due.pop_front();
      cmp("red", want.red, data[7:0]);
      cmp("green", want.green, data[15:8]);
      cmp("blue", want.blue, data[23:16]);
      cmp("alpha", want.alpha, data[31:24]);
      cmp("run_length", want.run_length, data[43:32]);
      cmp("pad", 0, data[47:44]);
      cmp("row_end", want.row_end, last);
    endfunction
  endclass

  run_tracker book;
  int items_sent = 0;
  int tx_busy = 20;
  int rx_busy = 20;
  int rx_hold = 0;
  int cycles = 0;

  slp_sprite_row_rle_decoder_unit #(
    .MAX_WIDTH(MAX_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: zero most of the time at low pressure, mostly short gaps,
  // now and then a long one.
  function automatic int pick_gap(int busy_pct);
    if ($urandom_range(0, 99) >= busy_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Pressure level: calm stretches with no idling, moderate, heavy.
  function automatic int pick_busy();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 20;
      default: return 60;
    endcase
  endfunction

  // Counts: mostly small so that copies stay short, sometimes the full range.
  function automatic int small_count(int lo_max, int hi_max);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, lo_max);
    return $urandom_range(0, hi_max);
  endfunction

  // Row sizes: mostly narrow, some up to the maximum, a few past it.
  function automatic logic [11:0] pick_size(int narrow);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 12'($urandom_range(0, narrow));
    if (roll < 92) return 12'($urandom_range(0, MAX_W));
    return 12'($urandom_range(MAX_W + 1, 4095));
  endfunction

  function automatic logic [55:0] junk();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[55:0];
  endfunction

  // Present one input item, hold it until the block takes it, then note it.
  // Called and returning at a rising edge.
  task automatic send_item(input logic [1:0] cmd, input logic [55:0] data);
    int gap;
    if ($urandom_range(0, 99) < 2) tx_busy = pick_busy();
    gap = pick_gap(tx_busy);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.take_item(cmd, data);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic send_row(input logic [11:0] left, input logic [11:0] width);
    logic [55:0] data;
    data = junk();
    data[19:8] = left;
    data[31:20] = width;
    send_item(slp_rle_pkg::CMD_ROW_START, data);
  endtask

  // Stream byte; steer palette indices onto entries that hold a color.
  task automatic send_stream(input logic [7:0] b);
    logic [55:0] data;
    logic [7:0] idx;
    idx = b;
    if (book.reads_palette()) begin
      while (!book.written[idx]) idx = 8'($urandom_range(0, 255));
    end
    data = junk();
    data[7:0] = idx;
    send_item(slp_rle_pkg::CMD_STREAM, data);
  endtask

  task automatic send_pal(input logic [7:0] idx, input logic [23:0] color);
    logic [55:0] data;
    data = junk();
    data[7:0] = idx;
    data[55:32] = color;
    send_item(slp_rle_pkg::CMD_PAL_WRITE, data);
  endtask

  task automatic send_random_bytes(input int n);
    repeat (n) send_stream(8'($urandom));
  endtask

  // One well-formed command with random content.
  task automatic gen_command();
    int n;
    logic [3:0] hi;
    logic [3:0] op;
    hi = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 8))
      0: begin
        n = small_count(6, 63);
        send_stream({n[5:0], slp_rle_pkg::OP_GRP_COPY});
        send_random_bytes(n);
      end
      1: begin
        n = small_count(12, 63);
        send_stream({n[5:0], slp_rle_pkg::OP_GRP_SKIP});
        if (n == 0) send_stream(8'(small_count(20, 255)));
      end
      2: begin
        send_stream({hi, slp_rle_pkg::OP_GREATER_COPY});
        n = small_count(6, 255);
        send_stream(8'(n));
        send_random_bytes(n);
      end
      3: begin
        send_stream({hi, slp_rle_pkg::OP_GREATER_SKIP});
        send_stream(8'(small_count(30, 255)));
      end
      4: begin
        send_stream({hi, slp_rle_pkg::OP_PLAYER_COPY});
        if (hi == 4'h0) begin
          n = small_count(6, 255);
          send_stream(8'(n));
        end else begin
          n = int'(hi);
        end
        send_random_bytes(n);
      end
      5: begin
        op = $urandom_range(0, 1) ? slp_rle_pkg::OP_PAL_FILL : slp_rle_pkg::OP_PLAYER_FILL;
        send_stream({hi, op});
        if (hi == 4'h0) send_stream(8'(small_count(20, 255)));
        send_random_bytes(1);
      end
      6: begin
        send_stream({hi, slp_rle_pkg::OP_SHADOW});
        if (hi == 4'h0) send_stream(8'(small_count(20, 255)));
      end
      7: begin
        send_stream({hi, OP_EXTENDED});
        if (hi == slp_rle_pkg::EXT_OUTLINE_A_X || hi == slp_rle_pkg::EXT_OUTLINE_B_X)
          send_random_bytes(1);
      end
      default: send_pal(8'($urandom), 24'($urandom));
    endcase
  endtask

  task automatic well_formed_row();
    send_row(pick_size(24), pick_size(64));
    repeat ($urandom_range(1, 8)) gen_command();
    send_stream({4'($urandom_range(0, 15)), slp_rle_pkg::OP_END_ROW});
  endtask

  // Loose bytes, palette writes, dropped kinds and stray row starts.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 3))
        0: send_random_bytes(1);
        1: send_pal(8'($urandom), 24'($urandom));
        2: send_item(CMD_UNUSED, junk());
        default: send_row(pick_size(24), pick_size(64));
      endcase
    end
  endtask

  // Row cut off in the middle of a command by the next row start.
  task automatic broken_row();
    send_row(pick_size(24), pick_size(64));
    if ($urandom_range(0, 1)) gen_command();
    send_stream(8'($urandom));
    send_random_bytes($urandom_range(0, 2));
  endtask

  // Result side: check every accepted run, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_run(m_axis_tdata, m_axis_tlast);
    if ($urandom_range(0, 99) < 2) rx_busy = pick_busy();
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_hold = pick_gap(rx_busy);
      m_axis_tready <= (rx_hold == 0);
      if (rx_hold > 0) rx_hold--;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_slp_sprite_row_rle_decoder_unit: errors");
      $finish;
    end
  end

  initial begin
    int target;
    int roll;
    book = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Load a few palette entries before anything reads them.
    send_pal(8'h00, 24'hFFFFFF);
    send_pal(8'hFF, 24'h000000);

    // Oversized margin and width saturate; extra pixels saturate the count;
    // the full row still closes with a zero-length padding run.
    send_row(12'hFFF, 12'hFFF);
    send_stream({6'd63, slp_rle_pkg::OP_GRP_SKIP});
    send_stream({4'h0, slp_rle_pkg::OP_END_ROW});

    // Walk every opcode but the row end in one row.
    send_row(12'd3, 12'd40);
    send_stream({6'd2, slp_rle_pkg::OP_GRP_COPY});
    // A palette write in the middle of a copy leaves the decoder alone.
    send_pal(8'h5A, 24'($urandom));
    send_stream(8'h00);
    send_stream(8'hFF);
    send_stream({6'd0, slp_rle_pkg::OP_GRP_SKIP});
    send_stream(8'd5);
    send_stream({4'h9, slp_rle_pkg::OP_GREATER_COPY});
    send_stream(8'd1);
    send_stream(8'h5A);
    // Zero-length skip: nothing comes out.
    send_stream({4'h0, slp_rle_pkg::OP_GREATER_SKIP});
    send_stream(8'd0);
    send_stream({4'h2, slp_rle_pkg::OP_PLAYER_COPY});
    send_random_bytes(2);
    send_stream({4'h1, slp_rle_pkg::OP_PAL_FILL});
    send_stream(8'h5A);
    // Fill with a zero count still takes its color byte.
    send_stream({4'h0, slp_rle_pkg::OP_PLAYER_FILL});
    send_stream(8'd0);
    send_stream(8'h33);
    send_stream({4'hF, slp_rle_pkg::OP_SHADOW});
    send_stream({slp_rle_pkg::EXT_OUTLINE_A, OP_EXTENDED});
    send_stream({slp_rle_pkg::EXT_OUTLINE_B_X, OP_EXTENDED});
    send_stream(8'hAB);
    // Unknown extended command: dropped.
    send_stream({4'h0, OP_EXTENDED});
    send_item(CMD_UNUSED, junk());
    // Abandon a copy with a new row start.
    send_stream({6'd3, slp_rle_pkg::OP_GRP_COPY});
    send_stream(8'hFF);
    send_row(12'd0, 12'd2048);
    send_stream({4'h0, slp_rle_pkg::OP_END_ROW});

    // Random part: mostly well-formed rows, the rest noise and broken rows.
    target = items_sent + RAND_ITEMS;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) well_formed_row();
      else if (roll < 85) noise_burst();
      else broken_row();
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then let the pipeline settle to catch stray results.
    while (book.runs_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (book.fails == 0 && book.runs_due.size() == 0) begin
      $display("tb_slp_sprite_row_rle_decoder_unit: clean");
    end else begin
      $display("tb_slp_sprite_row_rle_decoder_unit: errors");
    end
    $finish;
  end

endmodule
